[rtl/fbfla_pkg.sv]
package fbfla_pkg;

  // Pool geometry
  localparam int NumBlocks  = 64;
  localparam int BlockBytes = 1024;
  localparam int BlkW       = $clog2(NumBlocks);
  // One extra bit so that NumBlocks itself can mark the end of the list
  localparam int LinkW      = BlkW + 1;
  localparam int CountW     = 7;
  localparam int ReqW       = 16;

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_DESTROY = 2'd1,
    OP_ALLOC   = 2'd2,
    OP_FREE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EMPTY        = 3'd1,
    ST_TOO_LARGE    = 3'd2,
    ST_INIT_REFUSED = 3'd3,
    ST_FREE_IGNORED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_WALK = 2'd2,
    S_FIN  = 2'd3
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic execute;
    logic walk_step;
    logic init_done;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  op;
    logic count_zero;
    logic walk_last;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/fbfla_ram.sv]
module fbfla_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/fbfla_ctrl.sv]
module fbfla_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  fbfla_pkg::dp_status_t  stat_i,
  output fbfla_pkg::ctrl_cmd_t   ctl_o
);
  import fbfla_pkg::*;

  state_e state_q, state_d;
  logic   walk_needed;

  assign walk_needed = (stat_i.op == OP_INIT) && !stat_i.count_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (walk_needed) begin
          state_d = S_WALK;
        end else if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_WALK: begin
        if (stat_i.walk_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.load = in_valid_i;
      end
      S_EXEC: begin
        ctl_o.execute = !walk_needed && stat_i.out_free;
      end
      S_WALK: begin
        ctl_o.walk_step = 1'b1;
      end
      S_FIN: begin
        ctl_o.init_done = stat_i.out_free;
      end
      default: begin
        ctl_o = '0;
      end
    endcase
  end

endmodule

[rtl/fbfla_dp.sv]
module fbfla_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [fbfla_pkg::CountW-1:0]  cfg_data_i,
  input  logic [1:0]                    cmd_i,
  input  logic [fbfla_pkg::ReqW-1:0]    request_size_i,
  input  logic [fbfla_pkg::BlkW-1:0]    block_handle_i,
  input  logic                          handle_is_null_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [fbfla_pkg::BlkW-1:0]    granted_block_o,
  output logic [2:0]                    status_o,
  input  fbfla_pkg::ctrl_cmd_t          ctl_i,
  output fbfla_pkg::dp_status_t         stat_o
);
  import fbfla_pkg::*;

  localparam logic [ReqW:0]  MaxReq  = (ReqW+1)'(BlockBytes);
  localparam logic [LinkW-1:0] EndLink = LinkW'(NumBlocks);

  // Configuration
  logic [CountW-1:0] count_q;

  // Latched item
  op_e             op_q;
  logic [ReqW-1:0] req_q;
  logic [BlkW-1:0] hnd_q;
  logic            null_q;

  // Free list head and size-recorded flags
  logic [BlkW-1:0]      head_q, head_d;
  logic                 head_vld_q, head_vld_d;
  logic [NumBlocks-1:0] sized_q, sized_d;

  // Init walk
  logic [BlkW-1:0]  walk_q, walk_d;
  logic [LinkW-1:0] walk_n, walk_nxt;
  logic             walk_last;

  // Result register
  logic            out_valid_q, out_valid_d;
  logic [BlkW-1:0] out_blk_q;
  status_e         out_st_q;
  logic [BlkW-1:0] res_blk;
  status_e         res_st;
  logic            free_ok;

  // Link store port
  logic             ram_we;
  logic [BlkW-1:0]  ram_waddr;
  logic [LinkW-1:0] ram_wdata;
  logic [LinkW-1:0] link_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q   <= op_e'(cmd_i);
      req_q  <= request_size_i;
      hnd_q  <= block_handle_i;
      null_q <= handle_is_null_i;
    end
  end

  // Saturate the count to the pool size
  assign walk_n    = (count_q > CountW'(NumBlocks)) ? EndLink : LinkW'(count_q);
  assign walk_nxt  = {1'b0, walk_q} + LinkW'(1);
  assign walk_last = (walk_nxt == walk_n);

  always_comb begin
    walk_d = walk_q;
    if (ctl_i.load) begin
      walk_d = '0;
    end else if (ctl_i.walk_step) begin
      walk_d = walk_nxt[BlkW-1:0];
    end
  end

  always_comb begin
    head_d     = head_q;
    head_vld_d = head_vld_q;
    sized_d    = sized_q;
    res_blk    = '0;
    res_st     = ST_OK;
    free_ok    = 1'b0;
    if (ctl_i.execute) begin
      case (op_q)
        OP_INIT: begin
          res_st = ST_INIT_REFUSED;
        end
        OP_DESTROY: begin
          head_d     = '0;
          head_vld_d = 1'b0;
          sized_d    = '0;
        end
        OP_ALLOC: begin
          if ({1'b0, req_q} > MaxReq) begin
            res_st = ST_TOO_LARGE;
          end else if (!head_vld_q) begin
            res_st = ST_EMPTY;
          end else begin
            res_blk         = head_q;
            sized_d[head_q] = |req_q;
            if (link_rd < EndLink) begin
              head_d = link_rd[BlkW-1:0];
            end else begin
              head_d     = '0;
              head_vld_d = 1'b0;
            end
          end
        end
        OP_FREE: begin
          if (null_q || !sized_q[hnd_q]) begin
            res_st = ST_FREE_IGNORED;
          end else begin
            free_ok        = 1'b1;
            sized_d[hnd_q] = 1'b0;
            head_d         = hnd_q;
            head_vld_d     = 1'b1;
          end
        end
        default: begin
          res_st = ST_OK;
        end
      endcase
    end
    if (ctl_i.init_done) begin
      head_d     = '0;
      head_vld_d = 1'b1;
      sized_d    = '0;
    end
  end

  // Walk writes the ascending chain; a successful free links the old head
  assign ram_we    = ctl_i.walk_step || free_ok;
  assign ram_waddr = ctl_i.walk_step ? walk_q : hnd_q;
  always_comb begin
    if (ctl_i.walk_step) begin
      ram_wdata = walk_last ? EndLink : walk_nxt;
    end else begin
      ram_wdata = head_vld_q ? {1'b0, head_q} : EndLink;
    end
  end

  fbfla_ram #(
    .Width (LinkW),
    .Depth (NumBlocks)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctl_i.load),
    .raddr_i (head_q),
    .rdata_o (link_rd)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_i.execute || ctl_i.init_done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      head_vld_q  <= 1'b0;
      sized_q     <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      head_vld_q  <= head_vld_d;
      sized_q     <= sized_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.execute || ctl_i.init_done) begin
      out_blk_q <= res_blk;
      out_st_q  <= res_st;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_block_o = out_blk_q;
  assign status_o        = out_st_q;

  assign stat_o.op         = op_q;
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.walk_last  = walk_last;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_i.load, ctl_i.execute, ctl_i.walk_step, ctl_i.init_done}))
    else $error("more than one controller action in a cycle");

  a_result_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.execute || ctl_i.init_done) |-> (!out_valid_q || out_ready_i))
    else $error("result written over an untaken word");

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.walk_step |-> ({1'b0, walk_q} < walk_n))
    else $error("init walk past the block count");

  a_free_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.execute && free_ok) |=> (head_vld_q && (head_q == $past(hnd_q))))
    else $error("freed block not at the list head");

endmodule

[rtl/fixed_block_free_list_allocator_top.sv]
// Fixed-size block pool allocator. The pool holds 64 blocks of 1024 bytes,
// kept on a last-in-first-out free list: a head register and a 7-bit link
// per block held in a small RAM (a link value of 64 ends the list). Each
// input word carries one command: init links blocks 0 to block_count-1 in
// ascending order with block 0 at the head (block_count above 64 counts as
// 64, zero is refused with status 3); destroy empties the list; allocate
// pops the head and returns its index, or reports pool empty (1) or a
// request above 1024 bytes (2); free pushes a block back unless the handle
// is null or the block holds no recorded size, which gives status 4. Every
// command returns exactly one result word. Only whether a block's recorded
// size is zero is ever observed, so one flag per block is kept, cleared
// together by reset, init and destroy; the link RAM has no reset and no
// clearing pass, since only links written by init or free are ever read.
// One command is in flight at a time. Destroy, allocate, free and a refused
// init are accepted, run in the execute state and registered as the result
// word; allocate uses the registered link RAM read issued at acceptance. A
// successful init walks the saturated count, writing one link RAM entry a
// cycle, then a final step puts block 0 at the head. The result sits in an
// output register, so a word may be accepted while the previous result
// still waits; the command then holds at its last step until the output
// register is free. The block_count register is always ready; the user must
// write it only while idle, which the block itself does not enforce.
module fixed_block_free_list_allocator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fbfla_pkg::CountW-1:0]  cfg_data_i,
  // Command channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic [fbfla_pkg::ReqW-1:0]    request_size_i,
  input  logic [fbfla_pkg::BlkW-1:0]    block_handle_i,
  input  logic                          handle_is_null_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fbfla_pkg::BlkW-1:0]    granted_block_o,
  output logic [2:0]                    status_o
);
  import fbfla_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t stat;

  // Configuration register accepts a word on every cycle
  assign cfg_ready_o = 1'b1;

  // Sequence each command: accept, execute or walk, and hand over the result
  fbfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  // Hold the list state, the link RAM and the result register
  fbfla_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd_i),
    .request_size_i   (request_size_i),
    .block_handle_i   (block_handle_i),
    .handle_is_null_i (handle_is_null_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .granted_block_o  (granted_block_o),
    .status_o         (status_o),
    .ctl_i            (ctl),
    .stat_o           (stat)
  );

endmodule
